// ===== rtl/core/fcf_pkg.sv =====
// shared constants, payload types and control structs for the fir convolution filter
package fcf_pkg;

    localparam int MAX_TAPS    = 64;
    localparam int TAP_W       = $clog2(MAX_TAPS);
    localparam int SAMPLE_W    = 16;
    localparam int COEF_W      = 16;
    localparam int CNT_W       = 7;
    localparam int INDEX_W     = 6;
    localparam int FRAC_W      = 15;
    localparam int ACC_W       = 2 * SAMPLE_W + TAP_W;
    localparam int DIGIT_SH    = 2;
    localparam int DIGIT_W     = 1 << DIGIT_SH;
    localparam int DIGITS      = SAMPLE_W / DIGIT_W;
    localparam int DIGIT_IDX_W = $clog2(DIGITS);
    localparam int PP_W        = COEF_W + DIGIT_W + 1;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_COEF   = 1'b1;

    localparam logic [SAMPLE_W-1:0] OUT_MAX = 16'h7fff;
    localparam logic [SAMPLE_W-1:0] OUT_MIN = 16'h8000;

    typedef struct packed {
        logic                       cmd;
        logic signed [SAMPLE_W-1:0] sample_in;
        logic [INDEX_W-1:0]         coef_index;
        logic signed [COEF_W-1:0]   coef_value;
    } in_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_out;
        logic                       saturated;
    } out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_LOAD,
        ST_MAC,
        ST_ROUND
    } state_t;

    typedef struct packed {
        logic                   clear_acc;
        logic                   load_ops;
        logic                   mac_en;
        logic [DIGIT_IDX_W-1:0] digit;
    } mac_ctrl_t;

    typedef struct packed {
        logic             tap_we;
        logic [TAP_W-1:0] tap_waddr;
        logic             delay_we;
        logic [TAP_W-1:0] delay_waddr;
        logic [TAP_W-1:0] tap_raddr;
        logic [TAP_W-1:0] delay_raddr;
    } ram_ctrl_t;

endpackage

// ===== rtl/core/fcf_zram.sv =====
// single-port-write ram with registered read, entries read as zero until written
module fcf_zram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [DEPTH-1:0] written_reg;
    logic [DEPTH-1:0] written_next;
    logic [WIDTH-1:0] rdata_reg;
    logic             rvalid_reg;

    always_comb begin
        written_next = written_reg;
        if (we) begin
            written_next[waddr] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            written_reg <= '0;
            rvalid_reg  <= 1'b0;
        end else begin
            written_reg <= written_next;
            rvalid_reg  <= written_reg[raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rvalid_reg ? rdata_reg : '0;

endmodule

// ===== rtl/core/fcf_mac.sv =====
// digit-serial multiply-accumulate with rounding and saturation to q1.15
module fcf_mac (
    input  logic                               aclk,
    input  fcf_pkg::mac_ctrl_t                 ctrl,
    input  logic signed [fcf_pkg::COEF_W-1:0]   coef_rd,
    input  logic signed [fcf_pkg::SAMPLE_W-1:0] sample_rd,
    output fcf_pkg::out_t                      result
);
    import fcf_pkg::*;

    localparam int Y_W = ACC_W - FRAC_W;

    logic signed [COEF_W-1:0]   coef_reg;
    logic signed [COEF_W-1:0]   coef_next;
    logic signed [SAMPLE_W-1:0] x_sr_reg;
    logic signed [SAMPLE_W-1:0] x_sr_next;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [ACC_W-1:0]    acc_next;

    logic signed [DIGIT_W:0]         digit_s;
    logic signed [PP_W-1:0]          pp;
    logic signed [ACC_W-1:0]         pp_ext;
    logic [DIGIT_IDX_W+DIGIT_SH-1:0] shamt;
    logic signed [ACC_W-1:0]         rsum;
    logic [Y_W-1:0]                  y;
    logic [Y_W-SAMPLE_W:0]           y_hi;
    logic                            sat;

    // top digit carries the sign, the others are plain unsigned nibbles
    assign digit_s = {(ctrl.digit == DIGIT_IDX_W'(DIGITS - 1)) ? x_sr_reg[DIGIT_W-1] : 1'b0,
                      x_sr_reg[DIGIT_W-1:0]};
    assign pp      = coef_reg * digit_s;
    assign pp_ext  = ACC_W'(pp);
    assign shamt   = {ctrl.digit, DIGIT_SH'(0)};

    always_comb begin
        coef_next = coef_reg;
        x_sr_next = x_sr_reg;
        acc_next  = acc_reg;
        if (ctrl.clear_acc) begin
            acc_next = '0;
        end else if (ctrl.mac_en) begin
            acc_next = acc_reg + (pp_ext <<< shamt);
        end
        if (ctrl.load_ops) begin
            coef_next = coef_rd;
            x_sr_next = sample_rd;
        end else if (ctrl.mac_en) begin
            x_sr_next = x_sr_reg >>> DIGIT_W;
        end
    end

    always_ff @(posedge aclk) begin
        coef_reg <= coef_next;
        x_sr_reg <= x_sr_next;
        acc_reg  <= acc_next;
    end

    // round half up, then clip to 16 bits
    assign rsum = acc_reg + ACC_W'(1 << (FRAC_W - 1));
    assign y    = rsum[ACC_W-1:FRAC_W];
    assign y_hi = y[Y_W-1:SAMPLE_W-1];
    assign sat  = !((&y_hi) || !(|y_hi));

    always_comb begin
        result.saturated = sat;
        if (sat) begin
            result.sample_out = y[Y_W-1] ? OUT_MIN : OUT_MAX;
        end else begin
            result.sample_out = y[SAMPLE_W-1:0];
        end
    end

endmodule

// ===== rtl/core/fcf_ctrl.sv =====
// sequencer for the tap walk: pointers, digit counter and request handshake
module fcf_ctrl (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  fcf_pkg::in_t               s_data,
    input  logic                       m_valid,
    input  logic                       m_ready,
    input  logic [fcf_pkg::CNT_W-1:0]  tap_count,
    output fcf_pkg::mac_ctrl_t         mac_ctrl,
    output fcf_pkg::ram_ctrl_t         ram_ctrl,
    output logic                       out_load
);
    import fcf_pkg::*;

    localparam logic [DIGIT_IDX_W-1:0] LAST_DIGIT = DIGIT_IDX_W'(DIGITS - 1);

    state_t                 state_reg;
    state_t                 state_next;
    logic [TAP_W-1:0]       head_reg;
    logic [TAP_W-1:0]       head_next;
    logic [TAP_W-1:0]       rd_ptr_reg;
    logic [TAP_W-1:0]       rd_ptr_next;
    logic [TAP_W-1:0]       tap_idx_reg;
    logic [TAP_W-1:0]       tap_idx_next;
    logic [TAP_W-1:0]       last_idx_reg;
    logic [TAP_W-1:0]       last_idx_next;
    logic [DIGIT_IDX_W-1:0] digit_reg;
    logic [DIGIT_IDX_W-1:0] digit_next;

    logic [TAP_W-1:0] head_inc;
    logic [TAP_W-1:0] rd_dec;
    logic [TAP_W-1:0] tap_inc;
    logic [TAP_W-1:0] last_idx_in;
    logic             coef_ok;

    assign head_inc = (head_reg == TAP_W'(MAX_TAPS - 1)) ? '0 : head_reg + TAP_W'(1);
    assign rd_dec   = (rd_ptr_reg == '0) ? TAP_W'(MAX_TAPS - 1) : rd_ptr_reg - TAP_W'(1);
    assign tap_inc  = tap_idx_reg + TAP_W'(1);
    assign coef_ok  = (32'(s_data.coef_index) < MAX_TAPS);

    // zero taps behaves as one, anything past the memory as all of it
    always_comb begin
        if (tap_count == '0) begin
            last_idx_in = '0;
        end else if (32'(tap_count) > MAX_TAPS) begin
            last_idx_in = TAP_W'(MAX_TAPS - 1);
        end else begin
            last_idx_in = TAP_W'(tap_count - CNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            head_reg     <= '0;
            rd_ptr_reg   <= '0;
            tap_idx_reg  <= '0;
            last_idx_reg <= '0;
            digit_reg    <= '0;
        end else begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            rd_ptr_reg   <= rd_ptr_next;
            tap_idx_reg  <= tap_idx_next;
            last_idx_reg <= last_idx_next;
            digit_reg    <= digit_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        head_next     = head_reg;
        rd_ptr_next   = rd_ptr_reg;
        tap_idx_next  = tap_idx_reg;
        last_idx_next = last_idx_reg;
        digit_next    = digit_reg;

        s_ready  = 1'b0;
        out_load = 1'b0;

        mac_ctrl.clear_acc = 1'b0;
        mac_ctrl.load_ops  = 1'b0;
        mac_ctrl.mac_en    = 1'b0;
        mac_ctrl.digit     = digit_reg;

        ram_ctrl.tap_we      = 1'b0;
        ram_ctrl.tap_waddr   = TAP_W'(s_data.coef_index);
        ram_ctrl.delay_we    = 1'b0;
        ram_ctrl.delay_waddr = head_inc;
        // during the walk the next tap is prefetched
        ram_ctrl.tap_raddr   = (state_reg == ST_MAC) ? tap_inc : tap_idx_reg;
        ram_ctrl.delay_raddr = (state_reg == ST_MAC) ? rd_dec : rd_ptr_reg;

        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_data.cmd == CMD_COEF) begin
                        ram_ctrl.tap_we = coef_ok;
                    end else begin
                        ram_ctrl.delay_we  = 1'b1;
                        head_next          = head_inc;
                        rd_ptr_next        = head_inc;
                        tap_idx_next       = '0;
                        last_idx_next      = last_idx_in;
                        mac_ctrl.clear_acc = 1'b1;
                        state_next         = ST_FETCH;
                    end
                end
            end
            ST_FETCH: begin
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                mac_ctrl.load_ops = 1'b1;
                digit_next        = '0;
                state_next        = ST_MAC;
            end
            ST_MAC: begin
                mac_ctrl.mac_en = 1'b1;
                digit_next      = digit_reg + DIGIT_IDX_W'(1);
                if (digit_reg == LAST_DIGIT) begin
                    if (tap_idx_reg == last_idx_reg) begin
                        state_next = ST_ROUND;
                    end else begin
                        mac_ctrl.load_ops = 1'b1;
                        tap_idx_next      = tap_inc;
                        rd_ptr_next       = rd_dec;
                    end
                end
            end
            ST_ROUND: begin
                if (!m_valid || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_sample_starts_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.cmd == CMD_SAMPLE) |=> state_reg == ST_FETCH)
        else $error("sample request did not start the tap walk");

    a_tap_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MAC) |-> tap_idx_reg <= last_idx_reg)
        else $error("tap index ran past the last tap in use");

    a_out_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (state_reg == ST_ROUND && (!m_valid || m_ready)))
        else $error("result loaded over an untaken result");

    a_walk_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MAC || state_reg == ST_LOAD || state_reg == ST_FETCH) |-> !s_ready)
        else $error("input taken while a sample is in progress");
`endif

endmodule

// ===== rtl/core/fir_convolution_filter.sv =====
// top level of the streaming fir convolution filter
//
//   port group        direction  moves
//   s_valid/s_ready   in         one request: sample (cmd 0) or coefficient write (cmd 1)
//   m_valid/m_ready   out        one filtered q1.15 sample and a saturation flag
//   cfg_we/cfg_wdata  in         tap count in use
//
// a coefficient write is taken while idle; back-to-back writes run at one per cycle while no sample is in progress
// a sample is worked by one 16x5 multiplier that walks each tap in four
//   digit steps, with a fetch, an operand load and a rounding step around the walk
// the result register lets the next request in while the last result waits
// a finished sample holds in the rounding step until the result register is free
// after reset the tap and delay memories read as zero at once, no clearing pass
module fir_convolution_filter (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic [fcf_pkg::CNT_W-1:0] cfg_wdata,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  fcf_pkg::in_t              s_data,
    output logic                      m_valid,
    input  logic                      m_ready,
    output fcf_pkg::out_t             m_data
);
    import fcf_pkg::*;

    logic [CNT_W-1:0] tap_count_reg;
    logic [CNT_W-1:0] tap_count_next;
    logic             m_valid_reg;
    logic             m_valid_next;
    out_t             m_data_reg;
    out_t             m_data_next;

    mac_ctrl_t                  mac_ctrl;
    ram_ctrl_t                  ram_ctrl;
    logic                       out_load;
    logic signed [COEF_W-1:0]   coef_rd;
    logic signed [SAMPLE_W-1:0] sample_rd;
    out_t                       result;

    fcf_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid_reg),
        .m_ready   (m_ready),
        .tap_count (tap_count_reg),
        .mac_ctrl  (mac_ctrl),
        .ram_ctrl  (ram_ctrl),
        .out_load  (out_load)
    );

    fcf_zram #(
        .DEPTH (MAX_TAPS),
        .WIDTH (COEF_W)
    ) u_tap_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .we      (ram_ctrl.tap_we),
        .waddr   (ram_ctrl.tap_waddr),
        .wdata   (s_data.coef_value),
        .raddr   (ram_ctrl.tap_raddr),
        .rdata   (coef_rd)
    );

    fcf_zram #(
        .DEPTH (MAX_TAPS),
        .WIDTH (SAMPLE_W)
    ) u_delay_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .we      (ram_ctrl.delay_we),
        .waddr   (ram_ctrl.delay_waddr),
        .wdata   (s_data.sample_in),
        .raddr   (ram_ctrl.delay_raddr),
        .rdata   (sample_rd)
    );

    fcf_mac u_mac (
        .aclk      (aclk),
        .ctrl      (mac_ctrl),
        .coef_rd   (coef_rd),
        .sample_rd (sample_rd),
        .result    (result)
    );

    always_comb begin
        tap_count_next = cfg_we ? cfg_wdata : tap_count_reg;
        m_data_next    = out_load ? result : m_data_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tap_count_reg <= CNT_W'(1);
            m_valid_reg   <= 1'b0;
        end else begin
            tap_count_reg <= tap_count_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== sim/tb_fir_convolution_filter.sv =====
`timescale 1ns / 100ps
// self-checking testbench for the fir convolution filter: random and directed requests
module tb_fir_convolution_filter;
    import fcf_pkg::*;

    localparam int CLK_HALF        = 5;
    localparam int RESET_CYCLES    = 11;
    localparam int DRAIN_CYCLES    = 4 * MAX_TAPS + 40;
    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int HOLD_OFF_CYCLES = 600;
    localparam int SHOWN_ERRORS    = 10;

    logic             aclk      = 1'b0;
    logic             aresetn   = 1'b0;
    logic             cfg_we    = 1'b0;
    logic [CNT_W-1:0] cfg_wdata = '0;
    logic             s_valid   = 1'b0;
    logic             s_ready;
    in_t              s_data    = '0;
    logic             m_valid;
    logic             m_ready   = 1'b0;
    out_t             m_data;

    // filter state as the block should hold it
    logic signed [SAMPLE_W-1:0] history [MAX_TAPS];
    logic signed [COEF_W-1:0]   impulse [MAX_TAPS];
    logic [CNT_W-1:0]           tap_setting;

    in_t  request_queue [$];
    out_t expected_outputs [$];

    int   queued_total      = 0;
    int   accepted_total    = 0;
    int   send_idle_pct     = 0;
    int   stall_pct         = 0;
    int   hold_off_requests = 0;
    int   hold_off_served   = 0;
    int   hold_left         = 0;
    int   cycle_count       = 0;
    int   mismatches        = 0;
    int   samples_sent      = 0;
    int   coef_writes       = 0;
    int   clipped_results   = 0;
    int   settings_used     = 0;
    logic in_taken          = 1'b0;

    fir_convolution_filter dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always #CLK_HALF aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("no progress within %0d cycles", CYCLE_LIMIT);
            $display("tb_fir_convolution_filter failed");
            $finish;
        end
    end

    // applies one request to the filter state; returns 1 when it yields an output
    function automatic bit filter_request(input in_t req, output out_t res);
        longint acc;
        longint y;
        int     n;
        res = '0;
        if (req.cmd == CMD_COEF) begin
            impulse[req.coef_index] = req.coef_value;
            return 1'b0;
        end
        for (int k = MAX_TAPS - 1; k > 0; k--) history[k] = history[k-1];
        history[0] = req.sample_in;
        n = (tap_setting == 0) ? 1 : (tap_setting > MAX_TAPS) ? MAX_TAPS : int'(tap_setting);
        acc = 0;
        for (int k = 0; k < n; k++) acc += longint'(impulse[k]) * longint'(history[k]);
        y = (acc + 64'sd16384) >>> FRAC_W;
        if (y > 32767) begin
            y = 32767;
            res.saturated = 1'b1;
        end else if (y < -32768) begin
            y = -32768;
            res.saturated = 1'b1;
        end
        res.sample_out = y[SAMPLE_W-1:0];
        return 1'b1;
    endfunction

    always @(posedge aclk) begin : monitor
        out_t want;
        out_t got;
        if (!aresetn) begin
            in_taken = 1'b0;
        end else begin
            in_taken = s_valid && s_ready;
            if (in_taken) begin
                accepted_total++;
                if (filter_request(s_data, want)) begin
                    expected_outputs.push_back(want);
                    samples_sent++;
                end else begin
                    coef_writes++;
                end
            end
            if (m_valid && m_ready) begin
                got = m_data;
                if (expected_outputs.size() == 0) begin
                    mismatches++;
                    if (mismatches <= SHOWN_ERRORS)
                        $display("%0t: unexpected output %0d sat %0b", $time,
                                 got.sample_out, got.saturated);
                end else begin
                    want = expected_outputs.pop_front();
                    if (want.saturated) clipped_results++;
                    if (got.sample_out !== want.sample_out || got.saturated !== want.saturated) begin
                        mismatches++;
                        if (mismatches <= SHOWN_ERRORS)
                            $display("%0t: sample_out exp %0d got %0d, saturated exp %0b got %0b",
                                     $time, want.sample_out, got.sample_out,
                                     want.saturated, got.saturated);
                    end
                end
            end
        end
    end

    always @(negedge aclk) begin : driver
        logic offer;
        offer = s_valid && !in_taken;
        if (aresetn && !offer && request_queue.size() != 0
                && $urandom_range(99) >= send_idle_pct) begin
            s_data <= request_queue.pop_front();
            offer = 1'b1;
        end
        s_valid <= offer;
    end

    always @(negedge aclk) begin : receiver
        if (hold_off_served != hold_off_requests) begin
            hold_off_served = hold_off_requests;
            hold_left       = HOLD_OFF_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic logic [15:0] pick_value();
        case ($urandom_range(9))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'hffff;
            4: return 16'($urandom_range(255));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic in_t random_request(input int active);
        in_t req;
        req.cmd        = ($urandom_range(99) < 25) ? CMD_COEF : CMD_SAMPLE;
        req.sample_in  = pick_value();
        req.coef_index = ($urandom_range(3) == 0) ? INDEX_W'($urandom)
                                                  : INDEX_W'($urandom_range(active - 1));
        req.coef_value = pick_value();
        return req;
    endfunction

    function automatic in_t coef_req(input int idx, input logic [15:0] value);
        in_t req;
        req            = random_request(1);
        req.cmd        = CMD_COEF;
        req.coef_index = INDEX_W'(idx);
        req.coef_value = value;
        return req;
    endfunction

    function automatic in_t sample_req(input logic [15:0] value);
        in_t req;
        req           = random_request(1);
        req.cmd       = CMD_SAMPLE;
        req.sample_in = value;
        return req;
    endfunction

    task automatic send(input in_t req);
        request_queue.push_back(req);
        queued_total++;
    endtask

    task automatic wait_idle();
        do @(negedge aclk);
        while (accepted_total != queued_total || expected_outputs.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_taps(input int value);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= CNT_W'(value);
        @(negedge aclk);
        cfg_we      <= 1'b0;
        tap_setting  = CNT_W'(value);
        settings_used++;
    endtask

    task automatic run_phase(input int setting, input int items, input int idle_pct,
                             input int stall, input bit squeeze);
        int active;
        write_taps(setting);
        active        = (setting == 0) ? 1 : (setting > MAX_TAPS) ? MAX_TAPS : setting;
        send_idle_pct = idle_pct;
        stall_pct     = stall;
        repeat (items) send(random_request(active));
        if (squeeze) hold_off_requests++;
        wait_idle();
    endtask

    initial begin
        foreach (history[k]) begin
            history[k] = '0;
            impulse[k] = '0;
        end
        tap_setting = CNT_W'(1);
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;

        // one tap after reset
        send(coef_req(0, 16'h8000));
        send(sample_req(16'h8000));
        send(sample_req(16'h7fff));
        send(sample_req(16'h0000));
        send(coef_req(0, 16'h0001));
        send(sample_req(16'h4000));
        send(sample_req(16'hc000));
        send(sample_req(16'hffff));
        send(coef_req(63, 16'h7fff));
        send(coef_req(1, 16'h8000));
        send(coef_req(0, 16'h8000));
        wait_idle();
        // two full-scale taps clip negative
        write_taps(2);
        send(sample_req(16'h7fff));
        send(sample_req(16'h7fff));
        wait_idle();
        // zero tap count behaves as one tap
        write_taps(0);
        send(sample_req(16'h7fff));
        send(sample_req(16'h8000));
        wait_idle();
        // oversized tap count clamps to the full memory
        write_taps(127);
        send(coef_req(62, 16'h7fff));
        send(sample_req(16'h8000));
        send(sample_req(16'h1234));
        wait_idle();

        run_phase(4, 340, 0, 0, 1'b0);
        run_phase(8, 250, 86, 0, 1'b0);
        run_phase(3, 250, 0, 86, 1'b0);
        run_phase(6, 250, 14, 14, 1'b0);
        run_phase(64, 50, 0, 0, 1'b0);
        run_phase(2, 200, 0, 0, 1'b1);
        run_phase($urandom_range(16, 1), 200, 0, 86, 1'b0);
        run_phase(1, 150, 14, 14, 1'b0);
        run_phase(65, 40, 14, 14, 1'b0);

        $display("run covered %0d samples and %0d coefficient writes over %0d tap settings",
                 samples_sent, coef_writes, settings_used);
        $display("%0d outputs were clipped, %0d mismatches seen", clipped_results, mismatches);
        if (mismatches == 0) begin
            $display("tb_fir_convolution_filter passed");
        end else begin
            $display("tb_fir_convolution_filter failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/fcf_pkg.sv
rtl/core/fcf_zram.sv
rtl/core/fcf_mac.sv
rtl/core/fcf_ctrl.sv
rtl/core/fir_convolution_filter.sv
sim/tb_fir_convolution_filter.sv
